// ----- hdl/fir_convolution_filter_top_defines.svh -----
// Assertion shorthands used by the filter control RTL (fcf_ctrl).
// Each one is clocked on clk and disabled while rst_n is low.
`ifndef FIR_CONVOLUTION_FILTER_TOP_DEFINES_SVH
`define FIR_CONVOLUTION_FILTER_TOP_DEFINES_SVH

// Condition must hold on every clock edge.
`define FCF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define FCF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/fcf_pkg.sv -----
`default_nettype none

package fcf_pkg;

  // Payload and register widths
  localparam int POS_W  = 10;
  localparam int VAL_W  = 32;
  localparam int SMP_W  = VAL_W + 1;  // value plus missing flag
  localparam int TAP_W  = 6;
  localparam int LEN_W  = 11;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 11;

  // Item opcodes
  localparam logic [1:0] OP_COEF   = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_TAPS     = 2'd0;
  localparam logic [CFG_IW-1:0] REG_LEN      = 2'd1;
  localparam logic [CFG_IW-1:0] REG_CENTERED = 2'd2;
  localparam logic [CFG_IW-1:0] REG_CIRCULAR = 2'd3;

  // Per-tap control travelling alongside the memory reads
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic force_miss;
  } mac_ctl_t;

  // Finished sum from the MAC
  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] value;
    logic                    miss;
  } mac_res_t;

endpackage

`default_nettype wire

// ----- hdl/fcf_if.sv -----
`default_nettype none

interface fcf_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      op;
  logic [fcf_pkg::POS_W-1:0]       position;
  logic signed [fcf_pkg::VAL_W-1:0] value;
  logic                            is_missing;

  modport source (output valid, op, position, value, is_missing, input ready);
  modport sink   (input valid, op, position, value, is_missing, output ready);
endinterface

interface fcf_out_if;
  logic                             valid;
  logic                             ready;
  logic [fcf_pkg::POS_W-1:0]        out_position;
  logic signed [fcf_pkg::VAL_W-1:0] filtered_value;
  logic                             out_missing;

  modport source (output valid, out_position, filtered_value, out_missing, input ready);
  modport sink   (input valid, out_position, filtered_value, out_missing, output ready);
endinterface

`default_nettype wire

// ----- hdl/fcf_ram.sv -----
`default_nettype none

// Simple dual-port RAM with a registered read.
module fcf_ram #(
  parameter int DEPTH  = 32,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 5
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hdl/fcf_mac.sv -----
`default_nettype none

// Multiply, round to Q16.16, accumulate, saturate.
// Stage a: memory data lands. Stage b: product. Stage c: accumulate. Stage d: result.
module fcf_mac #(
  parameter int MAX_TAPS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire fcf_pkg::mac_ctl_t                  ctl,
  input  wire logic signed [fcf_pkg::VAL_W-1:0]   coef_rdata,
  input  wire logic        [fcf_pkg::SMP_W-1:0]   smp_rdata,
  output fcf_pkg::mac_res_t                       res
);

  localparam int PRD_W = 2 * fcf_pkg::VAL_W;
  localparam int RND_W = PRD_W - 16;
  localparam int ACW   = RND_W + $clog2(MAX_TAPS + 1) + 1;
  localparam logic signed [ACW-1:0] SAT_HI = ACW'(64'sd2147483647);
  localparam logic signed [ACW-1:0] SAT_LO = ACW'(-64'sd2147483648);

  fcf_pkg::mac_ctl_t       ctl_a_r, ctl_b_r;
  logic signed [PRD_W-1:0] prod_r;
  logic                    miss_b_r;
  logic signed [PRD_W-1:0] rnd;
  logic signed [ACW-1:0]   rnd_ext;
  logic signed [ACW-1:0]   acc_r, acc_nxt;
  logic                    miss_acc_r, miss_acc_nxt;
  logic                    fin_r;
  logic                    done_r;
  logic signed [fcf_pkg::VAL_W-1:0] res_val_r;
  logic                    res_miss_r;
  logic signed [fcf_pkg::VAL_W-1:0] sat_val;

  // floor((p + 2^15) / 2^16)
  assign rnd     = (prod_r + PRD_W'(32768)) >>> 16;
  assign rnd_ext = ACW'($signed(rnd[RND_W-1:0]));

  always_comb begin
    acc_nxt      = (ctl_b_r.first ? '0 : acc_r) + rnd_ext;
    miss_acc_nxt = (ctl_b_r.first ? 1'b0 : miss_acc_r) | miss_b_r;
  end

  always_comb begin
    if (acc_r > SAT_HI) begin
      sat_val = 32'sh7fffffff;
    end else if (acc_r < SAT_LO) begin
      sat_val = 32'sh80000000;
    end else begin
      sat_val = acc_r[fcf_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      fin_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      ctl_a_r <= ctl;
      ctl_b_r <= ctl_a_r;
      fin_r   <= ctl_b_r.vld & ctl_b_r.last;
      done_r  <= fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_a_r.vld) begin
      prod_r   <= $signed(coef_rdata) * $signed(smp_rdata[fcf_pkg::VAL_W-1:0]);
      miss_b_r <= smp_rdata[fcf_pkg::SMP_W-1] | ctl_a_r.force_miss;
    end
    if (ctl_b_r.vld) begin
      acc_r      <= acc_nxt;
      miss_acc_r <= miss_acc_nxt;
    end
    if (fin_r) begin
      res_val_r  <= miss_acc_r ? '0 : sat_val;
      res_miss_r <= miss_acc_r;
    end
  end

  assign res.done  = done_r;
  assign res.value = res_val_r;
  assign res.miss  = res_miss_r;

endmodule

`default_nettype wire

// ----- hdl/fcf_ctrl.sv -----
`default_nettype none
`include "fir_convolution_filter_top_defines.svh"

// Item intake, config registers, tap sequencer and result register.
module fcf_ctrl #(
  parameter int MAX_LEN  = 1024,
  parameter int MAX_TAPS = 32,
  parameter int SAW      = 10,
  parameter int CAW      = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  fcf_in_if.sink                             in_ch,
  fcf_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [fcf_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic [fcf_pkg::CFG_DW-1:0]    cfg_data,
  output logic                               coef_we,
  output logic [CAW-1:0]                     coef_waddr,
  output logic [fcf_pkg::VAL_W-1:0]          coef_wdata,
  output logic [CAW-1:0]                     coef_raddr,
  output logic                               smp_we,
  output logic [SAW-1:0]                     smp_waddr,
  output logic [fcf_pkg::SMP_W-1:0]          smp_wdata,
  output logic [SAW-1:0]                     smp_raddr,
  output fcf_pkg::mac_ctl_t                  mac_ctl,
  input  wire fcf_pkg::mac_res_t             mac_res
);

  localparam int NFW = $clog2(MAX_TAPS + 1);
  localparam int NNW = $clog2(MAX_LEN + 1);
  localparam int KW  = $clog2(MAX_LEN + MAX_TAPS + 1024);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WRAP  = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [fcf_pkg::TAP_W-1:0] taps_r;
  logic [fcf_pkg::LEN_W-1:0] len_r;
  logic                      centered_r, circular_r;

  logic [fcf_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [NNW-1:0]            nn_r, nn_nxt;
  logic [CAW-1:0]            last_j_r, last_j_nxt;
  logic [CAW-1:0]            j_r, j_nxt;
  logic [KW-1:0]             k_r, k_nxt;
  logic                      force_r, force_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [fcf_pkg::POS_W-1:0] out_pos_r;
  logic signed [fcf_pkg::VAL_W-1:0] out_val_r;
  logic                      out_miss_r;
  logic                      out_load;

  logic           in_acc;
  logic [NFW-1:0] nf;
  logic [NNW-1:0] nn;
  logic [NFW-1:0] shift;
  logic [KW-1:0]  base;
  logic           early_miss;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // clamp registers to their legal ranges
  always_comb begin
    if (taps_r == '0) begin
      nf = NFW'(1);
    end else if (32'(taps_r) > 32'(MAX_TAPS)) begin
      nf = NFW'(MAX_TAPS);
    end else begin
      nf = NFW'(taps_r);
    end
    if (len_r == '0) begin
      nn = NNW'(1);
    end else if (32'(len_r) > 32'(MAX_LEN)) begin
      nn = NNW'(MAX_LEN);
    end else begin
      nn = NNW'(len_r);
    end
  end

  assign shift = centered_r ? (nf >> 1) : '0;
  assign base  = KW'(in_ch.position) + KW'(shift);

  // query beyond series, or a linear window that runs off either end
  assign early_miss = (KW'(in_ch.position) >= KW'(nn)) ||
                      (!circular_r && ((base < (KW'(nf) - KW'(1))) || (base >= KW'(nn))));

  // store writes go straight to the RAMs
  assign coef_we    = in_acc && (in_ch.op == fcf_pkg::OP_COEF) &&
                      (32'(in_ch.position) < 32'(MAX_TAPS));
  assign coef_waddr = CAW'(in_ch.position);
  assign coef_wdata = in_ch.value;
  assign smp_we     = in_acc && (in_ch.op == fcf_pkg::OP_SAMPLE) &&
                      (32'(in_ch.position) < 32'(MAX_LEN));
  assign smp_waddr  = SAW'(in_ch.position);
  assign smp_wdata  = {in_ch.is_missing, in_ch.value};

  assign coef_raddr = j_r;
  assign smp_raddr  = k_r[SAW-1:0];

  assign mac_ctl.vld        = (state_r == ST_RUN);
  assign mac_ctl.first      = (j_r == '0);
  assign mac_ctl.last       = (j_r == last_j_r);
  assign mac_ctl.force_miss = force_r;

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    nn_nxt     = nn_r;
    last_j_nxt = last_j_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    force_nxt  = force_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.op == fcf_pkg::OP_QUERY)) begin
          pos_nxt    = in_ch.position;
          nn_nxt     = nn;
          j_nxt      = '0;
          force_nxt  = early_miss;
          last_j_nxt = early_miss ? '0 : CAW'(nf - NFW'(1));
          k_nxt      = early_miss ? '0 : base;
          state_nxt  = early_miss ? ST_RUN : ST_WRAP;
        end
      end
      ST_WRAP: begin
        // bring the first sample index into 0..nn-1
        if (k_r >= KW'(nn_r)) begin
          k_nxt = k_r - KW'(nn_r);
        end else begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        j_nxt = j_r + CAW'(1);
        k_nxt = (k_r == '0) ? (KW'(nn_r) - KW'(1)) : (k_r - KW'(1));
        if (j_r == last_j_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_res.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      taps_r      <= fcf_pkg::TAP_W'(1);
      len_r       <= fcf_pkg::LEN_W'(1);
      centered_r  <= 1'b0;
      circular_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          fcf_pkg::REG_TAPS:     taps_r     <= cfg_data[fcf_pkg::TAP_W-1:0];
          fcf_pkg::REG_LEN:      len_r      <= cfg_data[fcf_pkg::LEN_W-1:0];
          fcf_pkg::REG_CENTERED: centered_r <= cfg_data[0];
          fcf_pkg::REG_CIRCULAR: circular_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    nn_r     <= nn_nxt;
    last_j_r <= last_j_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    force_r  <= force_nxt;
    if (out_load) begin
      out_pos_r  <= pos_r;
      out_val_r  <= mac_res.value;
      out_miss_r <= mac_res.miss;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_position   = out_pos_r;
  assign out_ch.filtered_value = out_val_r;
  assign out_ch.out_missing    = out_miss_r;

  `FCF_ASSERT_IMPL(a_run_addr_in_series, (state_r == ST_RUN) && !force_r, k_r < KW'(nn_r), "sample read outside series")
  `FCF_ASSERT_IMPL(a_done_only_in_drain, mac_res.done, state_r == ST_DRAIN, "MAC result outside drain")
  `FCF_ASSERT_NEXT(a_query_starts, in_acc && (in_ch.op == fcf_pkg::OP_QUERY), state_r != ST_IDLE, "query not started")
  `FCF_ASSERT_ALWAYS(a_tap_bound, (state_r != ST_RUN) || (j_r <= last_j_r), "tap index past last")

endmodule

`default_nettype wire

// ----- hdl/fir_convolution_filter_top.sv -----
`default_nettype none

// Channel   Dir  Payload                                        Transfer
// in_ch     in   op, position, value, is_missing                valid & ready
// out_ch    out  out_position, filtered_value, out_missing      valid & ready
// cfg_*     in   cfg_index, cfg_data                            cfg_we
//
// Writes (op 0/1) go straight to the stores; op 3 is dropped.
// A query runs one MAC per tap (nf = taps in use), bound by the single read port
// of each store; in circular mode the first sample index may need repeated
// reduction by the length before the taps start. in_ch is not ready during a query.
// Reset: synchronous, active-low rst_n; registers return to 1 tap, length 1,
// one-sided, linear; store contents are not cleared. A stalled out_ch holds one result.
module fir_convolution_filter_top #(
  parameter int MAX_LEN  = 1024,
  parameter int MAX_TAPS = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  fcf_in_if.sink                          in_ch,
  fcf_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [fcf_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [fcf_pkg::CFG_DW-1:0] cfg_data
);

  // store address widths
  localparam int SAW = $clog2(MAX_LEN);
  localparam int CAW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  logic                      coef_we;
  logic [CAW-1:0]            coef_waddr, coef_raddr;
  logic [fcf_pkg::VAL_W-1:0] coef_wdata, coef_rdata;
  logic                      smp_we;
  logic [SAW-1:0]            smp_waddr, smp_raddr;
  logic [fcf_pkg::SMP_W-1:0] smp_wdata, smp_rdata;
  fcf_pkg::mac_ctl_t         mac_ctl;
  fcf_pkg::mac_res_t         mac_res;

  // Sequencer: takes items, writes stores, walks taps, holds the result
  fcf_ctrl #(
    .MAX_LEN  (MAX_LEN),
    .MAX_TAPS (MAX_TAPS),
    .SAW      (SAW),
    .CAW      (CAW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .coef_wdata (coef_wdata),
    .coef_raddr (coef_raddr),
    .smp_we     (smp_we),
    .smp_waddr  (smp_waddr),
    .smp_wdata  (smp_wdata),
    .smp_raddr  (smp_raddr),
    .mac_ctl    (mac_ctl),
    .mac_res    (mac_res)
  );

  // Coefficient store
  fcf_ram #(
    .DEPTH  (MAX_TAPS),
    .WIDTH  (fcf_pkg::VAL_W),
    .ADDR_W (CAW)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  // Sample store: {missing, value}
  fcf_ram #(
    .DEPTH  (MAX_LEN),
    .WIDTH  (fcf_pkg::SMP_W),
    .ADDR_W (SAW)
  ) u_smp_ram (
    .clk   (clk),
    .we    (smp_we),
    .waddr (smp_waddr),
    .wdata (smp_wdata),
    .raddr (smp_raddr),
    .rdata (smp_rdata)
  );

  // Multiply-accumulate pipeline, lined up with the RAM read latency
  fcf_mac #(
    .MAX_TAPS (MAX_TAPS)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mac_ctl),
    .coef_rdata (coef_rdata),
    .smp_rdata  (smp_rdata),
    .res        (mac_res)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_fir_convolution_filter_top.sv -----
module tb_fir_convolution_filter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fcf_pkg::*;

  localparam int MAX_LEN  = 1024;
  localparam int MAX_TAPS = 32;

  // op 3 has no name in the package; the block drops it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // target count of items the block acts on (writes in range and queries)
  localparam int ITEM_TARGET = 1650;
  // settle time in cycles before a register write
  localparam int IDLE_PAD    = 64;
  // timeout in cycles, several times the slowest legal run
  localparam int LIMIT       = 1_500_000;
  localparam int PRINT_CAP   = 30;

  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct packed {
    logic [1:0]              op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    logic                    is_missing;
  } fir_item_t;

  typedef struct packed {
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    logic                    missing;
  } fir_out_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and the block
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic              cfg_we    = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data  = '0;

  fcf_in_if  in_if ();
  fcf_out_if out_if ();

  // driver and monitor registers; they feed the interfaces continuously
  logic      drv_valid = 1'b0;
  fir_item_t drv_item  = '0;
  logic      mon_ready = 1'b0;

  assign in_if.valid      = drv_valid;
  assign in_if.op         = drv_item.op;
  assign in_if.position   = drv_item.position;
  assign in_if.value      = drv_item.value;
  assign in_if.is_missing = drv_item.is_missing;
  assign out_if.ready     = mon_ready;

  fir_convolution_filter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Bookkeeping shared by stimulus, driver and monitor
  // ---------------------------------------------------------------------------
  fir_item_t items_to_send [$];  // items waiting for the driver
  fir_out_t  due_outputs [$];    // filter outputs owed by the block, oldest first
  int        issued     = 0;     // items queued for transfer
  int        taken      = 0;     // items transferred into the block
  int        acted_on   = 0;     // queued items that are not dropped by the block
  int        mismatches = 0;
  int        cycles     = 0;

  // ---------------------------------------------------------------------------
  // Filter predictor: own copy of the stores and of the registers
  // ---------------------------------------------------------------------------
  logic signed [VAL_W-1:0] tap_coef  [MAX_TAPS];
  logic signed [VAL_W-1:0] smp_value [MAX_LEN];
  logic                    smp_gone  [MAX_LEN];

  logic [TAP_W-1:0] taps_reg = 6'd1;
  logic [LEN_W-1:0] len_reg  = 11'd1;
  logic             cen_reg  = 1'b0;
  logic             circ_reg = 1'b0;

  // register shadow follows every write the block sees
  always @(posedge clk) begin
    if (!rst_n) begin
      taps_reg <= 6'd1;
      len_reg  <= 11'd1;
      cen_reg  <= 1'b0;
      circ_reg <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAPS:     taps_reg <= cfg_data[TAP_W-1:0];
        REG_LEN:      len_reg  <= cfg_data[LEN_W-1:0];
        REG_CENTERED: cen_reg  <= cfg_data[0];
        REG_CIRCULAR: circ_reg <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Applies one transferred item; a query appends the output it must produce.
  function automatic void fir_apply(input fir_item_t it);
    int       nf, nn, shift, i, j, k;
    longint   acc, prod;
    logic     miss;
    fir_out_t res;
    case (it.op)
      OP_COEF: begin
        if (it.position < MAX_TAPS) tap_coef[it.position] = it.value;
      end
      OP_SAMPLE: begin
        smp_value[it.position] = it.value;
        smp_gone[it.position]  = it.is_missing;
      end
      OP_QUERY: begin
        // registers out of range are clamped when used
        nf = (taps_reg == 0) ? 1 : ((taps_reg > MAX_TAPS) ? MAX_TAPS : int'(taps_reg));
        nn = (len_reg == 0) ? 1 : ((len_reg > MAX_LEN) ? MAX_LEN : int'(len_reg));
        shift = cen_reg ? nf / 2 : 0;
        i = int'(it.position);
        acc = 0;
        miss = 1'b0;
        if (i >= nn) begin
          miss = 1'b1;
        end else if (!circ_reg && (i + shift - (nf - 1) < 0 || i + shift >= nn)) begin
          miss = 1'b1;  // window runs off an end of the series
        end else begin
          for (j = 0; j < nf; j++) begin
            k = i + shift - j;
            if (circ_reg) begin
              k = k % nn;
              if (k < 0) k += nn;
            end
            if (smp_gone[k]) begin
              miss = 1'b1;
              break;
            end
            prod = longint'(tap_coef[j]) * longint'(smp_value[k]);
            acc += (prod + 64'sd32768) >>> 16;  // round half up to Q16.16
          end
        end
        if (miss) acc = 0;
        else if (acc > SUM_MAX) acc = SUM_MAX;
        else if (acc < SUM_MIN) acc = SUM_MIN;
        res.position = it.position;
        res.value    = acc[VAL_W-1:0];
        res.missing  = miss;
        due_outputs.push_back(res);
      end
      default: ;  // op 3: dropped, no output
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Idle pattern for both sides: mostly short gaps, a few long ones, and for one
  // quarter of the time a stretch with no gaps at all.
  // ---------------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    if ((cycles / 1500) % 4 == 3) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued items; on each transfer the predictor is stepped
  // with the item the block just took, then the next one follows directly or
  // after a gap.
  // ---------------------------------------------------------------------------
  int drv_gap = 0;

  always @(posedge clk) begin : drive_items
    int g;
    if (!rst_n) begin
      drv_valid <= 1'b0;
      drv_gap   <= 0;
    end else if (drv_valid && in_if.ready) begin
      fir_apply(drv_item);
      taken++;
      g = gap_len();
      if (items_to_send.size() != 0 && g == 0) begin
        drv_item <= items_to_send.pop_front();  // valid stays high
      end else begin
        drv_valid <= 1'b0;
        drv_gap   <= g;
      end
    end else if (!drv_valid) begin
      if (drv_gap != 0) begin
        drv_gap <= drv_gap - 1;
      end else if (items_to_send.size() != 0) begin
        drv_item  <= items_to_send.pop_front();
        drv_valid <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure on the output; each transfer is checked
  // against the oldest owed output.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_output();
    fir_out_t want;
    if (due_outputs.size() == 0) begin
      report_mismatch($sformatf("output at position %0d with no query waiting",
                                out_if.out_position));
      return;
    end
    want = due_outputs.pop_front();
    if (out_if.out_position !== want.position)
      report_mismatch($sformatf("out_position %0d, want %0d",
                                out_if.out_position, want.position));
    if (out_if.filtered_value !== want.value)
      report_mismatch($sformatf("position %0d: filtered_value %h, want %h",
                                want.position, out_if.filtered_value, want.value));
    if (out_if.out_missing !== want.missing)
      report_mismatch($sformatf("position %0d: out_missing %b, want %b",
                                want.position, out_if.out_missing, want.missing));
  endtask

  int mon_hold = 0;

  always @(posedge clk) begin : watch_outputs
    int h;
    if (!rst_n) begin
      mon_ready <= 1'b0;
      mon_hold  <= 0;
    end else begin
      if (out_if.valid && out_if.ready) check_output();
      if (mon_hold != 0) begin
        mon_hold  <= mon_hold - 1;
        mon_ready <= 1'b0;
      end else begin
        h = gap_len();
        if (h != 0) begin
          mon_hold  <= h - 1;
          mon_ready <= 1'b0;
        end else begin
          mon_ready <= 1'b1;
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb_fir_convolution_filter_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus side. The stores are undefined until written, so the generator
  // tracks what it has loaded and writes every coefficient and sample that a
  // query will read before the query goes out.
  // ---------------------------------------------------------------------------
  bit coef_loaded   [MAX_TAPS];
  bit sample_loaded [MAX_LEN];

  // effective settings as the generator sees them
  int gen_nf    = 1;
  int gen_nn    = 1;
  int gen_shift = 0;
  bit gen_circ  = 1'b0;

  // fixed settings for the first phases: extremes, wrap with taps past the
  // length, and both kinds of clamped register values
  int preset_taps [7] = '{32, 1, 32, 7, 0, 63, 32};
  int preset_len  [7] = '{1024, 1, 1024, 3, 0, 2047, 5};
  int preset_cen  [7] = '{1, 0, 0, 1, 1, 1, 0};
  int preset_circ [7] = '{0, 1, 1, 1, 0, 1, 1};

  task automatic push_item(input logic [1:0] op, input int pos,
                           input logic [VAL_W-1:0] val, input logic miss);
    fir_item_t it;
    it.op         = op;
    it.position   = pos[POS_W-1:0];
    it.value      = val;
    it.is_missing = miss;
    if (op == OP_COEF && pos < MAX_TAPS) coef_loaded[pos] = 1'b1;
    if (op == OP_SAMPLE) sample_loaded[it.position] = 1'b1;
    if (op == OP_SAMPLE || op == OP_QUERY || (op == OP_COEF && pos < MAX_TAPS))
      acted_on++;
    items_to_send.push_back(it);
    issued++;
  endtask

  // Q16.16 values: edge values, full-range noise, or small values of +-2^(span-16)
  function automatic logic [VAL_W-1:0] rand_q16(input int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 8))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        3: return 32'h0001_0000;
        4: return 32'hFFFF_0000;
        5: return 32'h0000_8000;
        6: return 32'hFFFF_8000;
        7: return 32'hFFFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end
    if (r < 40) return $urandom();
    return int'($urandom_range(0, (1 << (span + 1)) - 1)) - (1 << span);
  endfunction

  function automatic logic rand_gone();
    return ($urandom_range(0, 29) == 0);
  endfunction

  // Wait until every item is in, every output is out, and writes have settled.
  task automatic wait_idle();
    while (taken != issued || due_outputs.size() != 0) @(posedge clk);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  task automatic set_regs(input int taps, input int len, input int cen, input int circ);
    int t, n;
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TAPS;
    cfg_data  <= taps[CFG_DW-1:0];
    @(posedge clk);
    cfg_index <= REG_LEN;
    cfg_data  <= len[CFG_DW-1:0];
    @(posedge clk);
    cfg_index <= REG_CENTERED;
    cfg_data  <= cen[CFG_DW-1:0];
    @(posedge clk);
    cfg_index <= REG_CIRCULAR;
    cfg_data  <= circ[CFG_DW-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    t = taps & 'h3F;
    n = len & 'h7FF;
    gen_nf    = (t == 0) ? 1 : ((t > MAX_TAPS) ? MAX_TAPS : t);
    gen_nn    = (n == 0) ? 1 : ((n > MAX_LEN) ? MAX_LEN : n);
    gen_shift = cen[0] ? gen_nf / 2 : 0;
    gen_circ  = circ[0];
  endtask

  // Query an output index, loading whatever part of its window is still unwritten.
  task automatic push_query(input int pos);
    int j, k;
    if (pos < gen_nn &&
        (gen_circ || (pos + gen_shift - (gen_nf - 1) >= 0 && pos + gen_shift < gen_nn))) begin
      for (j = 0; j < gen_nf; j++) begin
        if (!coef_loaded[j]) push_item(OP_COEF, j, rand_q16(17), $urandom_range(0, 1));
        k = pos + gen_shift - j;
        if (gen_circ) begin
          k = k % gen_nn;
          if (k < 0) k += gen_nn;
        end
        if (!sample_loaded[k]) push_item(OP_SAMPLE, k, rand_q16(22), rand_gone());
      end
    end
    push_item(OP_QUERY, pos, $urandom(), $urandom_range(0, 1));
  endtask

  task automatic push_random_item();
    int r, d, pos;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      d = $urandom_range(0, 99);
      if (d < 70) begin
        pos = $urandom_range(0, gen_nn - 1);
      end else if (d < 85) begin
        // near either end of the series
        pos = $urandom_range(0, gen_nf);
        if ($urandom_range(0, 1)) pos = gen_nn - 1 - pos;
        if (pos < 0) pos = 0;
        if (pos > MAX_LEN - 1) pos = MAX_LEN - 1;
      end else begin
        pos = $urandom_range(0, MAX_LEN - 1);  // often past the series
      end
      push_query(pos);
    end else if (r < 78) begin
      pos = ($urandom_range(0, 9) < 7) ? $urandom_range(0, gen_nn - 1)
                                       : $urandom_range(0, MAX_LEN - 1);
      push_item(OP_SAMPLE, pos, rand_q16(22), rand_gone());
    end else if (r < 93) begin
      pos = ($urandom_range(0, 4) != 0) ? $urandom_range(0, gen_nf - 1)
                                        : $urandom_range(0, MAX_LEN - 1);
      push_item(OP_COEF, pos, rand_q16(17), $urandom_range(0, 1));
    end else begin
      push_item(OP_UNUSED, $urandom_range(0, MAX_LEN - 1), $urandom(), $urandom_range(0, 1));
    end
  endtask

  function automatic int flag_data();
    int v;
    v = $urandom_range(0, 1);
    // now and then junk in the upper bits; only bit 0 counts
    if ($urandom_range(0, 7) == 0) v |= $urandom_range(0, 1023) << 1;
    return v;
  endfunction

  initial begin : stimulus
    int phase, r, taps, len, n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: reset settings (1 tap, length 1, one-sided, linear) ---
    push_item(OP_COEF, 0, 32'h0001_0000, 1'b1);
    push_item(OP_SAMPLE, 0, 32'h7FFF_FFFF, 1'b0);
    push_query(0);     // passes the largest sample through unchanged
    push_query(1);     // beyond the series
    push_query(MAX_LEN - 1);
    push_item(OP_UNUSED, MAX_LEN - 1, 32'hFFFF_FFFF, 1'b1);   // dropped
    push_item(OP_COEF, MAX_LEN - 1, 32'h8000_0000, 1'b0);     // past the store, ignored
    push_query(0);

    // --- two taps, linear: saturation both ways, edges, missing sample ---
    set_regs(2, 4, 0, 0);
    push_item(OP_SAMPLE, 0, 32'h7FFF_FFFF, 1'b0);
    push_item(OP_SAMPLE, 1, 32'h7FFF_FFFF, 1'b0);
    push_item(OP_SAMPLE, 2, 32'h8000_0000, 1'b0);
    push_item(OP_SAMPLE, 3, 32'h8000_0000, 1'b0);
    push_item(OP_COEF, 0, 32'h7FFF_FFFF, 1'b0);
    push_item(OP_COEF, 1, 32'h7FFF_FFFF, 1'b0);
    push_query(0);     // left edge
    push_query(1);     // positive saturation
    push_query(3);     // negative saturation
    push_query(2);
    push_item(OP_SAMPLE, 2, 32'h0000_8000, 1'b1);
    push_query(2);     // missing sample in the window
    push_query(4);     // beyond the series

    // --- centered, linear: right edge and missing sample ahead of the index ---
    set_regs(3, 4, 1, 0);
    push_query(3);
    push_query(1);
    push_query(2);

    // --- phases: fixed extremes first, then random settings ---
    phase = 0;
    while (acted_on < ITEM_TARGET) begin
      if (phase < 7) begin
        set_regs(preset_taps[phase], preset_len[phase], preset_cen[phase], preset_circ[phase]);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50)      taps = $urandom_range(1, 8);
        else if (r < 80) taps = $urandom_range(9, MAX_TAPS);
        else if (r < 90) taps = MAX_TAPS;
        else if (r < 95) taps = $urandom_range(0, 1) ? 0 : $urandom_range(33, 63);
        else             taps = $urandom_range(0, 2047);  // only the low 6 bits count
        taps = (taps == 0 && r < 90) ? 1 : taps;
        r = $urandom_range(0, 99);
        if (r < 45)      len = $urandom_range(1, 40);
        else if (r < 75) len = $urandom_range(41, 200);
        else if (r < 85) len = $urandom_range(1, (taps & 'h3F) == 0 ? 1 : (taps & 'h3F));
        else if (r < 92) len = MAX_LEN;
        else             len = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_LEN + 1, 2047);
        set_regs(taps, len, flag_data(), flag_data());
      end
      n = $urandom_range(30, 110);
      // a query can pull in a whole window of loads, so stop once the target is met
      repeat (n) if (acted_on < ITEM_TARGET) push_random_item();
      phase++;
    end

    // drain: all items in, all outputs back, then the settle time
    wait_idle();
    if (due_outputs.size() != 0) report_mismatch("outputs still owed at the end");
    if (mismatches == 0) begin
      $display("tb_fir_convolution_filter_top OK");
    end else begin
      $display("tb_fir_convolution_filter_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- fir_convolution_filter_top.f -----
+incdir+hdl
hdl/fcf_pkg.sv
hdl/fcf_if.sv
hdl/fcf_ram.sv
hdl/fcf_mac.sv
hdl/fcf_ctrl.sv
hdl/fir_convolution_filter_top.sv
tb/sv/tb_fir_convolution_filter_top.sv
